>>> rtl/core/tbfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbfe_pkg: shared types and constants of the track biphase frame encoder
// Mode and item-kind codes, register indexes, reset values, sync tick counts and the result beat.
// ----------------------------------------------------------------------------
package tbfe_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_SYNC  = 2'd1,
		MODE_DATA  = 2'd2,
		MODE_STUFF = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READY = 2'd2,
		KIND_RUN   = 2'd3
	} kind_t;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 4;

	localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_REPEAT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STUFF_RUN    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_ENABLE = 2'd2;

	localparam logic [3:0] SYNC_REPEAT_RST = 4'd3;
	localparam logic [3:0] STUFF_RUN_RST   = 4'd8;

	// Sync pattern: toggle on these tick counts, close the pattern at the end count
	localparam logic [7:0] SYNC_T1  = 8'd1;
	localparam logic [7:0] SYNC_T3  = 8'd3;
	localparam logic [7:0] SYNC_T4  = 8'd4;
	localparam logic [7:0] SYNC_T6  = 8'd6;
	localparam logic [7:0] SYNC_T8  = 8'd8;
	localparam logic [7:0] SYNC_T9  = 8'd9;
	localparam logic [7:0] SYNC_END = 8'd10;

	typedef struct packed {
		logic track_a;
		logic track_b;
		logic track_enable;
		logic sending;
		logic pending;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/core/tbfe_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbfe_if: item and result channels of the track biphase frame encoder
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tbfe_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [6:0] bit_index;
	logic       bit_value;
	logic [6:0] msg_length;
	logic       run;

	modport source (output valid, output kind, output bit_index, output bit_value,
		output msg_length, output run, input ready);
	modport sink (input valid, input kind, input bit_index, input bit_value,
		input msg_length, input run, output ready);
endinterface

interface tbfe_result_if;
	logic valid;
	logic ready;
	logic track_a;
	logic track_b;
	logic track_enable;
	logic sending;
	logic pending;

	modport source (output valid, output track_a, output track_b, output track_enable,
		output sending, output pending, input ready);
	modport sink (input valid, input track_a, input track_b, input track_enable,
		input sending, input pending, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tbfe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbfe_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module tbfe_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/track_biphase_frame_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// track_biphase_frame_encoder_unit: sync pattern and biphase mark track encoder
// Drives the two-wire track from one item per half-bit tick, with bit stuffing.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input channel. kind selects a tick, a message bit
//            write, a message-ready mark or a run-mode change.
//   result : valid/ready output channel, one beat for every item beat, with
//            track levels, driver enable, sending and pending flags.
//   cfg    : write port (cfg_we, cfg_index, cfg_data) for sync_repeat,
//            stuff_run and drive_enable; write only while the block is idle.
// The result beat is registered in the output buffer; one item is taken in
// every cycle while item.ready is high. The message store is a RAM whose read
// is issued at the next bit pointer and registered, with a write bypass, so
// the data half-bit always sees the current stored bit.
// Reset puts the block in idle with the line polarity at one and the
// registers at their defaults; the message store is not cleared.
// The result side has a two-beat buffer: when the receiver stalls, one more
// item is accepted, then item.ready drops until a result beat leaves.
// ----------------------------------------------------------------------------
module track_biphase_frame_encoder_unit #(
	parameter int unsigned BUFFER_DEPTH = 128
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	tbfe_item_if.sink                              item,
	tbfe_result_if.source                          result,
	input  wire logic                              cfg_we,
	input  wire logic [tbfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [tbfe_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);

	logic [3:0]          sync_repeat_q;
	logic [3:0]          stuff_run_q;
	logic                drive_enable_q;

	tbfe_pkg::mode_t     mode_q, mode_d;
	logic [7:0]          tick_count_q, tick_count_d;
	logic [7:0]          sync_count_q, sync_count_d;
	logic [3:0]          ones_run_q, ones_run_d;
	logic                half_phase_q, half_phase_d;
	logic [7:0]          bit_pointer_q, bit_pointer_d;
	logic [6:0]          bits_left_q, bits_left_d;
	logic [6:0]          stored_length_q, stored_length_d;
	logic                pending_q, pending_d;
	logic                polarity_q, polarity_d;
	logic                pin_q, pin_d;

	logic                in_fire;
	tbfe_pkg::kind_t     kind;
	logic                toggle;
	logic                ram_we;
	logic                ram_rdata;
	logic                byp_hit_q;
	logic                byp_val_q;
	logic                cur_bit;
	logic                ptr_in_range;
	logic [3:0]          ones_inc;
	logic [6:0]          bits_dec;

	tbfe_pkg::result_t   res;
	tbfe_pkg::result_t   out_q, skid_q;
	logic                out_v_q, skid_v_q;
	logic                pop;

	assign in_fire    = item.valid && item.ready;
	assign item.ready = !skid_v_q;
	assign kind       = tbfe_pkg::kind_t'(item.kind);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_repeat_q  <= tbfe_pkg::SYNC_REPEAT_RST;
			stuff_run_q    <= tbfe_pkg::STUFF_RUN_RST;
			drive_enable_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == tbfe_pkg::CFG_SYNC_REPEAT) begin
				sync_repeat_q <= cfg_data[3:0];
			end
			if (cfg_index == tbfe_pkg::CFG_STUFF_RUN) begin
				stuff_run_q <= cfg_data[3:0];
			end
			if (cfg_index == tbfe_pkg::CFG_DRIVE_ENABLE) begin
				drive_enable_q <= cfg_data[0];
			end
		end
	end

	// Message store: read issued at the next pointer and registered, bypass same-cycle writes
	assign ram_we = in_fire && (kind == tbfe_pkg::KIND_WRITE)
		&& ({2'b00, item.bit_index} < 9'(BUFFER_DEPTH));

	tbfe_ram #(
		.WIDTH (1),
		.DEPTH (BUFFER_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(item.bit_index)),
		.wdata (item.bit_value),
		.raddr (bit_pointer_d[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
		end else begin
			byp_hit_q <= ram_we && (AW'(item.bit_index) == bit_pointer_d[AW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		byp_val_q <= item.bit_value;
	end

	assign ptr_in_range = {1'b0, bit_pointer_q} < 9'(BUFFER_DEPTH);
	assign cur_bit      = ptr_in_range && (byp_hit_q ? byp_val_q : ram_rdata);
	assign ones_inc     = ones_run_q + 4'd1;
	assign bits_dec     = bits_left_q - 7'd1;

	always_comb begin
		mode_d          = mode_q;
		tick_count_d    = tick_count_q;
		sync_count_d    = sync_count_q;
		ones_run_d      = ones_run_q;
		half_phase_d    = half_phase_q;
		bit_pointer_d   = bit_pointer_q;
		bits_left_d     = bits_left_q;
		stored_length_d = stored_length_q;
		pending_d       = pending_q;
		toggle          = 1'b0;
		if (in_fire) begin
			unique case (kind)
				tbfe_pkg::KIND_TICK: begin
					tick_count_d = tick_count_q + 8'd1;
					unique case (mode_q)
						tbfe_pkg::MODE_SYNC: begin
							if (tick_count_d == tbfe_pkg::SYNC_T1
								|| tick_count_d == tbfe_pkg::SYNC_T3
								|| tick_count_d == tbfe_pkg::SYNC_T4
								|| tick_count_d == tbfe_pkg::SYNC_T6
								|| tick_count_d == tbfe_pkg::SYNC_T8
								|| tick_count_d == tbfe_pkg::SYNC_T9) begin
								toggle = 1'b1;
							end else if (tick_count_d == tbfe_pkg::SYNC_END) begin
								if (pending_q && (sync_count_q > {4'd0, sync_repeat_q})) begin
									pending_d     = 1'b0;
									sync_count_d  = 8'd0;
									ones_run_d    = 4'd0;
									half_phase_d  = 1'b1;
									bit_pointer_d = 8'd1;
									bits_left_d   = stored_length_q;
									mode_d        = tbfe_pkg::MODE_DATA;
								end else begin
									tick_count_d = 8'd0;
									sync_count_d = sync_count_q + 8'd1;
								end
							end
						end
						tbfe_pkg::MODE_DATA: begin
							half_phase_d = !half_phase_q;
							if (half_phase_q) begin
								toggle = 1'b1;
							end else begin
								if (cur_bit) begin
									toggle = 1'b1;
									if (ones_inc == stuff_run_q) begin
										ones_run_d = 4'd0;
										mode_d     = tbfe_pkg::MODE_STUFF;
									end else begin
										ones_run_d = ones_inc;
									end
								end else begin
									ones_run_d = 4'd0;
								end
								bit_pointer_d = bit_pointer_q + 8'd1;
								bits_left_d   = bits_dec;
								if (bits_dec == 7'd0) begin
									mode_d       = tbfe_pkg::MODE_SYNC;
									tick_count_d = 8'd0;
								end
							end
						end
						tbfe_pkg::MODE_STUFF: begin
							half_phase_d = !half_phase_q;
							if (half_phase_q) begin
								toggle = 1'b1;
							end else begin
								mode_d = tbfe_pkg::MODE_DATA;
							end
						end
						tbfe_pkg::MODE_IDLE: begin
						end
					endcase
				end
				tbfe_pkg::KIND_WRITE: begin
				end
				tbfe_pkg::KIND_READY: begin
					stored_length_d = item.msg_length;
					pending_d       = 1'b1;
				end
				tbfe_pkg::KIND_RUN: begin
					mode_d = item.run ? tbfe_pkg::MODE_SYNC : tbfe_pkg::MODE_IDLE;
				end
			endcase
		end
		pin_d      = toggle ? !polarity_q : pin_q;
		polarity_d = toggle ? !polarity_q : polarity_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= tbfe_pkg::MODE_IDLE;
			tick_count_q    <= 8'd0;
			sync_count_q    <= 8'd0;
			ones_run_q      <= 4'd0;
			half_phase_q    <= 1'b0;
			bit_pointer_q   <= 8'd0;
			bits_left_q     <= 7'd0;
			stored_length_q <= 7'd0;
			pending_q       <= 1'b0;
			polarity_q      <= 1'b1;
			pin_q           <= 1'b0;
		end else begin
			mode_q          <= mode_d;
			tick_count_q    <= tick_count_d;
			sync_count_q    <= sync_count_d;
			ones_run_q      <= ones_run_d;
			half_phase_q    <= half_phase_d;
			bit_pointer_q   <= bit_pointer_d;
			bits_left_q     <= bits_left_d;
			stored_length_q <= stored_length_d;
			pending_q       <= pending_d;
			polarity_q      <= polarity_d;
			pin_q           <= pin_d;
		end
	end

	// Result beat and two-entry output buffer
	always_comb begin
		res.track_a      = pin_d;
		res.track_b      = !pin_d;
		res.track_enable = drive_enable_q;
		res.sending      = (mode_d == tbfe_pkg::MODE_DATA) || (mode_d == tbfe_pkg::MODE_STUFF);
		res.pending      = pending_d;
	end

	assign pop = out_v_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign result.valid        = out_v_q;
	assign result.track_a      = out_q.track_a;
	assign result.track_b      = out_q.track_b;
	assign result.track_enable = out_q.track_enable;
	assign result.sending      = out_q.sending;
	assign result.pending      = out_q.pending;

	// Checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without an output beat");

	a_stuff_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == tbfe_pkg::MODE_STUFF) |-> (ones_run_q == 4'd0))
		else $error("ones run not cleared in stuffed zero");

	a_start_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == tbfe_pkg::MODE_SYNC && mode_d == tbfe_pkg::MODE_DATA) |=> !pending_q)
		else $error("message start left pending set");

	a_tracks_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.track_a != out_q.track_b))
		else $error("track outputs not complementary");

endmodule
`default_nettype wire
